@@ rtl/core/fifo_queue_with_search_defines.svh @@
// ----------------------------------------------------------------------------
// fifo_queue_with_search_defines.svh
// Assertion macros shared by the queue RTL.
// ----------------------------------------------------------------------------
`ifndef FIFO_QUEUE_WITH_SEARCH_DEFINES_SVH
`define FIFO_QUEUE_WITH_SEARCH_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define FQS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define FQS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/fqs_pkg.sv @@
// ----------------------------------------------------------------------------
// fqs_pkg
// Types and constants shared by the searchable queue.
// ----------------------------------------------------------------------------
package fqs_pkg;

   localparam int FQS_DEPTH_DEFAULT = 16;
   localparam int VALUE_W           = 32;
   localparam int ACTION_W          = 2;

   typedef enum logic [ACTION_W-1:0] {
      ACT_ENQUEUE = 2'd0,
      ACT_SEARCH  = 2'd1,
      ACT_DEQUEUE = 2'd2,
      ACT_CLEAR   = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DEQ_WAIT,
      ST_SEARCH,
      ST_FINISH
   } state_type;

endpackage

@@ rtl/core/fifo_queue_with_search.sv @@
// ----------------------------------------------------------------------------
// fifo_queue_with_search
// First-in first-out queue of signed 32-bit words with a linear search.
// ----------------------------------------------------------------------------
// A queue of up to DEPTH signed words held in a ring inside a RAM. Each
// request word carries an action: enqueue req_value at the tail, search for
// req_value, dequeue the head, or clear the queue. Exactly one response word
// follows each request. A search reports the position, counted from the
// head, of the oldest matching entry. An enqueue on a full queue and a
// dequeue on an empty queue change nothing and return rsp_accepted low.
// Every response reports the occupancy after the action. The block handles
// one request at a time, stepping through ST_EXEC, then on a non-empty queue
// ST_DEQ_WAIT for a dequeue or ST_SEARCH for a search, then ST_FINISH, which
// waits for the output register to be free. A search compares at most the
// occupancy, so at most DEPTH, entries. The search time is set by the single
// RAM read port, which delivers one stored entry per cycle to the one
// comparator. A new request is taken as soon as the block is back in idle,
// even while the previous response is still held in the output register.
// ----------------------------------------------------------------------------
`include "fifo_queue_with_search_defines.svh"

module fifo_queue_with_search
   import fqs_pkg::*;
#(
   parameter int DEPTH = FQS_DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // Request channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [ACTION_W-1:0]              req_action,
   input  logic signed [VALUE_W-1:0]        req_value,
   // Response channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_accepted,
   output logic                             rsp_found,
   output logic [$clog2(DEPTH)-1:0]         rsp_position,
   output logic signed [VALUE_W-1:0]        rsp_removed_value,
   output logic [$clog2(DEPTH+1)-1:0]       rsp_occupancy
);

   // Ring index width and entry count width.
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [IDX_W:0]   DEPTH_X = (IDX_W + 1)'(DEPTH);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

   // Control state.
   state_type        state_ff, state_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Latched request and working result.
   action_type               action_ff, action_in;
   logic [VALUE_W-1:0]       value_ff, value_in;
   logic [IDX_W-1:0]         offset_ff, offset_in;
   logic                     res_accepted_ff, res_accepted_in;
   logic                     res_found_ff, res_found_in;
   logic [IDX_W-1:0]         res_position_ff, res_position_in;
   logic [VALUE_W-1:0]       res_removed_ff, res_removed_in;

   // Response output register.
   logic                     rsp_accepted_ff, rsp_accepted_in;
   logic                     rsp_found_ff, rsp_found_in;
   logic [IDX_W-1:0]         rsp_position_ff, rsp_position_in;
   logic [VALUE_W-1:0]       rsp_removed_ff, rsp_removed_in;
   logic [CNT_W-1:0]         rsp_occupancy_ff, rsp_occupancy_in;

   // RAM interface.
   logic                     ram_wr_en;
   logic                     ram_rd_en;
   logic [VALUE_W-1:0]       ram_rd_data;

   // Shared ring-slot unit: slot = (head + offset) mod DEPTH. Both operands
   // are below DEPTH, so one conditional subtract is enough.
   logic [IDX_W-1:0]         slot_off;
   logic [IDX_W:0]           slot_sum;
   logic [IDX_W:0]           slot_wrap;
   logic [IDX_W-1:0]         slot;

   logic                     req_accept;
   logic                     out_free;
   logic                     is_match;
   logic                     is_last;
   logic                     queue_empty;
   logic                     queue_full;

   assign req_accept  = req_valid && !req_stall;
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign queue_empty = (count_ff == '0);
   assign queue_full  = (count_ff == DEPTH_C);
   assign is_match    = (ram_rd_data == value_ff);
   assign is_last     = ((CNT_W'(offset_ff) + CNT_W'(1)) == count_ff);

   // The offset fed to the slot unit depends on what the sequencer is doing.
   always_comb begin
      case (state_ff)
         ST_EXEC: begin
            slot_off = (action_ff == ACT_ENQUEUE) ? count_ff[IDX_W-1:0] : '0;
         end
         ST_DEQ_WAIT: begin
            slot_off = IDX_W'(1);
         end
         ST_SEARCH: begin
            slot_off = offset_ff + IDX_W'(1);
         end
         default: begin
            slot_off = '0;
         end
      endcase
   end

   assign slot_sum  = {1'b0, head_ff} + {1'b0, slot_off};
   assign slot_wrap = slot_sum - DEPTH_X;
   assign slot      = (slot_sum >= DEPTH_X) ? slot_wrap[IDX_W-1:0] : slot_sum[IDX_W-1:0];

   fqs_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (slot),
      .wr_data (value_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (slot),
      .rd_data (ram_rd_data)
   );

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (action_ff == ACT_DEQUEUE && !queue_empty) begin
               state_in = ST_DEQ_WAIT;
            end else if (action_ff == ACT_SEARCH && !queue_empty) begin
               state_in = ST_SEARCH;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_DEQ_WAIT: begin
            state_in = ST_FINISH;
         end
         ST_SEARCH: begin
            if (is_match || is_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output and datapath logic.
   always_comb begin
      req_stall        = (state_ff != ST_IDLE);
      ram_wr_en        = 1'b0;
      ram_rd_en        = 1'b0;
      head_in          = head_ff;
      count_in         = count_ff;
      action_in        = action_ff;
      value_in         = value_ff;
      offset_in        = offset_ff;
      res_accepted_in  = res_accepted_ff;
      res_found_in     = res_found_ff;
      res_position_in  = res_position_ff;
      res_removed_in   = res_removed_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_accepted_in  = rsp_accepted_ff;
      rsp_found_in     = rsp_found_ff;
      rsp_position_in  = rsp_position_ff;
      rsp_removed_in   = rsp_removed_ff;
      rsp_occupancy_in = rsp_occupancy_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               action_in = action_type'(req_action);
               value_in  = req_value;
            end
         end
         ST_EXEC: begin
            res_accepted_in = 1'b1;
            res_found_in    = 1'b0;
            res_position_in = '0;
            res_removed_in  = '0;
            offset_in       = '0;
            case (action_ff)
               ACT_ENQUEUE: begin
                  if (queue_full) begin
                     res_accepted_in = 1'b0;
                  end else begin
                     ram_wr_en = 1'b1;
                     count_in  = count_ff + CNT_W'(1);
                  end
               end
               ACT_SEARCH: begin
                  // Fetch the head entry; the compare happens next cycle.
                  ram_rd_en = !queue_empty;
               end
               ACT_DEQUEUE: begin
                  if (queue_empty) begin
                     res_accepted_in = 1'b0;
                  end else begin
                     ram_rd_en = 1'b1;
                  end
               end
               default: begin
                  head_in  = '0;
                  count_in = '0;
               end
            endcase
         end
         ST_DEQ_WAIT: begin
            res_removed_in = ram_rd_data;
            head_in        = slot;
            count_in       = count_ff - CNT_W'(1);
         end
         ST_SEARCH: begin
            if (is_match) begin
               res_found_in    = 1'b1;
               res_position_in = offset_ff;
            end else if (!is_last) begin
               // Fetch the next entry while this one is discarded.
               ram_rd_en = 1'b1;
               offset_in = offset_ff + IDX_W'(1);
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_accepted_in  = res_accepted_ff;
               rsp_found_in     = res_found_ff;
               rsp_position_in  = res_position_ff;
               rsp_removed_in   = res_removed_ff;
               rsp_occupancy_in = count_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff        <= action_in;
      value_ff         <= value_in;
      offset_ff        <= offset_in;
      res_accepted_ff  <= res_accepted_in;
      res_found_ff     <= res_found_in;
      res_position_ff  <= res_position_in;
      res_removed_ff   <= res_removed_in;
      rsp_accepted_ff  <= rsp_accepted_in;
      rsp_found_ff     <= rsp_found_in;
      rsp_position_ff  <= rsp_position_in;
      rsp_removed_ff   <= rsp_removed_in;
      rsp_occupancy_ff <= rsp_occupancy_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_accepted      = rsp_accepted_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_position      = rsp_position_ff;
   assign rsp_removed_value = rsp_removed_ff;
   assign rsp_occupancy     = rsp_occupancy_ff;

   // The entry count never passes the ring size.
   `FQS_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= DEPTH_C, "count over depth")
   // Once a request word is taken, no other is taken in the next cycle.
   `FQS_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_accept, req_stall, "request overlap")
   // A hit lies inside the queue and comes from an accepted action.
   `FQS_ASSERT_NOW(a_hit_inside, clock, reset, rsp_valid && rsp_found,
      rsp_accepted && (CNT_W'(rsp_position) < rsp_occupancy), "hit outside queue")
   // A removed word is reported only for a dequeue that took effect.
   `FQS_ASSERT_NOW(a_removed_ok, clock, reset, rsp_valid && (rsp_removed_value != '0),
      rsp_accepted && !rsp_found, "removed word without dequeue")

endmodule

@@ rtl/core/fqs_ram.sv @@
// ----------------------------------------------------------------------------
// fqs_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module fqs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
